// ----- hw/rtl/hfa_pkg.sv -----
`default_nettype none

package hfa_pkg;

    // Default sizes of the hole table.
    localparam int HOLES_DEF     = 16;
    localparam int SIZE_BITS_DEF = 16;

    // Fixed field widths of the channels.
    localparam int INDEX_BITS  = 4;
    localparam int AMOUNT_BITS = 16;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam int FIT_MODE_BITS  = 2;
    localparam int COUNT_BITS     = 5;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLE_COUNT = 2'd1;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Fit modes; the unused code behaves as first fit.
    localparam logic [FIT_MODE_BITS-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_MODE_BITS-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_MODE_BITS-1:0] FIT_WORST = 2'd2;

    typedef struct packed {
        logic                   operation;
        logic [INDEX_BITS-1:0]  hole_index;
        logic [AMOUNT_BITS-1:0] amount;
        logic                   last_request;
    } in_item_t;

    typedef struct packed {
        logic                   granted;
        logic [INDEX_BITS-1:0]  chosen_hole;
        logic [AMOUNT_BITS-1:0] size_before;
        logic                   last_result;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_write;
        logic start_alloc;
        logic scan_read;
        logic commit;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic limit_zero;
        logic scan_last;
        logic slot_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hfa_ram.sv -----
`default_nettype none

module hfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hfa_ctrl.sv -----
`default_nettype none

module hfa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                operation,
    input  wire hfa_pkg::dp_status_t status,
    output hfa_pkg::ctl_cmd_t        cmd
);

    import hfa_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && operation == OP_ALLOC)
                begin
                    state_next = status.limit_zero ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.load_write  = in_valid && operation == OP_LOAD;
                cmd.start_alloc = in_valid && operation == OP_ALLOC;
            end
            ST_SCAN:
            begin
                cmd.scan_read = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_COMMIT:
            begin
                cmd.commit = status.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hfa_datapath.sv -----
`default_nettype none

module hfa_datapath #(
    parameter int HOLES     = hfa_pkg::HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire hfa_pkg::in_item_t                    in_item,
    input  wire logic [hfa_pkg::FIT_MODE_BITS-1:0]    fit_mode,
    input  wire logic [hfa_pkg::COUNT_BITS-1:0]       hole_count,
    input  wire hfa_pkg::ctl_cmd_t                    cmd,
    output hfa_pkg::dp_status_t                       status,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output hfa_pkg::out_item_t                        out_item
);

    import hfa_pkg::*;

    localparam int IDX_W = (HOLES > 1) ? $clog2(HOLES) : 1;
    localparam int CNT_W = $clog2(HOLES + 1);

    logic [CNT_W-1:0]     limit;
    logic                 load_in_range;

    logic [SIZE_BITS-1:0] req_reg;
    logic                 last_reg;
    logic [IDX_W-1:0]     scan_idx_reg;
    logic                 rd_pending_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_valid_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] best_reg;
    logic [HOLES-1:0]     valid_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_BITS-1:0] ram_wdata;
    logic [SIZE_BITS-1:0] ram_rdata;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 fits;
    logic                 take;

    // Saturate the configured count to the table size.
    always_comb
    begin
        if (32'(hole_count) > HOLES)
        begin
            limit = CNT_W'(HOLES);
        end
        else
        begin
            limit = CNT_W'(hole_count);
        end
    end

    assign load_in_range     = 32'(in_item.hole_index) < HOLES;
    assign status.limit_zero = limit == '0;
    assign status.scan_last  = (CNT_W'(scan_idx_reg) + CNT_W'(1)) == limit;
    assign status.slot_free  = !out_valid_reg || out_ready;

    // One write port shared by loads and by the write-back of a grant.
    assign ram_we    = (cmd.load_write && load_in_range) || (cmd.commit && found_reg);
    assign ram_waddr = cmd.commit ? pick_reg : IDX_W'(in_item.hole_index);
    assign ram_wdata = cmd.commit ? (best_reg - req_reg) : SIZE_BITS'(in_item.amount);

    hfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (HOLES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_read),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // A hole never written since reset reads as zero.
    assign rd_size = rd_valid_reg ? ram_rdata : '0;
    assign fits    = rd_pending_reg && (rd_size >= req_reg);

    always_comb
    begin
        take = 1'b0;
        if (fits)
        begin
            if (!found_reg)
            begin
                take = 1'b1;
            end
            else if (fit_mode == FIT_BEST && rd_size < best_reg)
            begin
                take = 1'b1;
            end
            else if (fit_mode == FIT_WORST && rd_size > best_reg)
            begin
                take = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_pending_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            rd_pending_reg <= cmd.scan_read;
            if (cmd.start_alloc)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_alloc)
        begin
            req_reg      <= SIZE_BITS'(in_item.amount);
            last_reg     <= in_item.last_request;
            scan_idx_reg <= '0;
            pick_reg     <= '0;
            best_reg     <= '0;
        end
        else
        begin
            if (cmd.scan_read)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            if (take)
            begin
                pick_reg <= rd_idx_reg;
                best_reg <= rd_size;
            end
        end
        if (cmd.scan_read)
        begin
            rd_idx_reg   <= scan_idx_reg;
            rd_valid_reg <= valid_reg[scan_idx_reg];
        end
        if (cmd.commit)
        begin
            out_item_reg.granted     <= found_reg;
            out_item_reg.chosen_hole <= found_reg ? INDEX_BITS'(pick_reg) : '0;
            out_item_reg.size_before <= found_reg ? AMOUNT_BITS'(best_reg) : '0;
            out_item_reg.last_result <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/hole_fit_allocator_core.sv -----
`default_nettype none
// A load transaction is taken while idle and gives no result. An allocate transaction
// scans min(hole_count, HOLES) holes through the one RAM read port, one per cycle; its
// result is registered after the scan and a drain state (directly, with no scan, for a
// zero count), once the previous result has been taken; the controller then returns to
// idle to take the next transaction. Asynchronous active-low reset clears the configuration,
// the control state and the per-hole valid bits, so every hole reads as zero until loaded.

module hole_fit_allocator_core #(
    parameter int HOLES     = hfa_pkg::HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire hfa_pkg::in_item_t                    in_item,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output hfa_pkg::out_item_t                        out_item,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hfa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [hfa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    import hfa_pkg::*;

    logic [FIT_MODE_BITS-1:0] fit_mode_reg;
    logic [COUNT_BITS-1:0]    hole_count_reg;
    ctl_cmd_t                 ctl_cmd;
    dp_status_t               dp_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= FIT_FIRST;
            hole_count_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIT_MODE:   fit_mode_reg   <= cfg_data[FIT_MODE_BITS-1:0];
                CFG_HOLE_COUNT: hole_count_reg <= cfg_data[COUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    hfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (in_item.operation),
        .status    (dp_status),
        .cmd       (ctl_cmd)
    );

    hfa_datapath #(
        .HOLES     (HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .fit_mode   (fit_mode_reg),
        .hole_count (hole_count_reg),
        .cmd        (ctl_cmd),
        .status     (dp_status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

`ifndef SYNTHESIS
    // A result is only loaded when the output register is free or draining.
    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.commit |-> (!out_valid || out_ready))
        else $error("result loaded over a pending transaction");

    // A hole write from the input side only happens on an accepted load.
    a_load_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.load_write |-> (in_valid && in_ready && in_item.operation == OP_LOAD))
        else $error("load write without an accepted load transaction");

    // A granted hole lies inside the searched range.
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.granted) |->
            (32'(out_item.chosen_hole) < 32'(hole_count_reg)))
        else $error("granted hole outside the searched range");

    // A refused request reports zero index and zero size.
    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.granted) |->
            (out_item.chosen_hole == '0 && out_item.size_before == '0))
        else $error("refused request with nonzero fields");
`endif

endmodule

`default_nettype wire
